// File: design/fevs_pkg.sv
// ----------------------------------------------------------------------------
// fevs_pkg - shared types for the fluid exchange valve sequencer
// Operating modes, sequence phases, register indexes and the structs that
// pass a request, its result and the configuration between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fevs_pkg;

    typedef enum logic [1:0] {
        MODE_NEUTRAL = 2'd0,
        MODE_MANUAL  = 2'd1,
        MODE_SEMI    = 2'd2,
        MODE_AUTO    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEAT    = 3'd1,
        PH_DRAIN   = 3'd2,
        PH_BALANCE = 3'd3,
        PH_FINISH  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        REG_TEMPERATURE_TARGET  = 2'd0,
        REG_OUTLET_VOLUME_TARGET = 2'd1,
        REG_INLET_VOLUME_TARGET = 2'd2,
        REG_DIFFERENCE_LIMIT    = 2'd3
    } t_reg_idx;

    localparam int unsigned ApbAddrWidth = 4;
    localparam int unsigned ApbDataWidth = 32;

    typedef struct packed {
        t_mode              mode;
        logic               start_request;
        logic               interrupt_request;
        logic               semi_inlet_request;
        logic               semi_outlet_request;
        logic               manual_inlet;
        logic               manual_outlet;
        logic signed [15:0] temperature;
        logic [15:0]        inlet_volume;
        logic [15:0]        outlet_volume;
        logic signed [16:0] volume_difference;
    } t_item;

    typedef struct packed {
        logic       inlet_valve;
        logic       outlet_valve;
        logic       bypass_valve;
        logic [2:0] phase_number;
    } t_result;

    typedef struct packed {
        logic signed [15:0] temperature_target;
        logic [15:0]        outlet_volume_target;
        logic [15:0]        inlet_volume_target;
        logic [15:0]        difference_limit;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/fevs_regs.sv
// ----------------------------------------------------------------------------
// fevs_regs - configuration register file
// Four 16-bit set-points written and read over a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module fevs_regs import fevs_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ApbAddrWidth-1:0] paddr,
    input  wire logic [ApbDataWidth-1:0] pwdata,
    output logic      [ApbDataWidth-1:0] prdata,
    output logic                         pready,
    output t_cfg                         o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TEMPERATURE_TARGET:   r_cfg.temperature_target   <= pwdata[15:0];
                REG_OUTLET_VOLUME_TARGET: r_cfg.outlet_volume_target <= pwdata[15:0];
                REG_INLET_VOLUME_TARGET:  r_cfg.inlet_volume_target  <= pwdata[15:0];
                REG_DIFFERENCE_LIMIT:     r_cfg.difference_limit     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_TEMPERATURE_TARGET:   prdata[15:0] = r_cfg.temperature_target;
            REG_OUTLET_VOLUME_TARGET: prdata[15:0] = r_cfg.outlet_volume_target;
            REG_INLET_VOLUME_TARGET:  prdata[15:0] = r_cfg.inlet_volume_target;
            REG_DIFFERENCE_LIMIT:     prdata[15:0] = r_cfg.difference_limit;
            default:                  prdata       = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/fevs_seq.sv
// ----------------------------------------------------------------------------
// fevs_seq - sequencer state and per-tick decision logic
// Holds the phase, valve commands and sticky request flags, and works out the
// result of one control tick in a single pass of combinational logic.
// ----------------------------------------------------------------------------
`default_nettype none

module fevs_seq import fevs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  t_item        i_item,
    input  t_cfg         i_cfg,
    output t_result      o_result
);

    t_phase     r_phase, n_phase;
    logic       r_inlet_cmd, n_inlet_cmd;
    logic       r_outlet_cmd, n_outlet_cmd;
    logic       r_bypass_cmd, n_bypass_cmd;
    logic       r_start, n_start;
    logic       r_intr, n_intr;
    logic       r_semi_in, n_semi_in;
    logic       r_semi_out, n_semi_out;
    logic [2:0] r_report, n_report;

    logic signed [17:0] w_diff;
    logic signed [17:0] w_lim;
    logic signed [17:0] w_nlim;
    logic               w_temp_done;

    // Balance comparison operands: the difference sign-extended, the limit zero-extended.
    assign w_diff      = {i_item.volume_difference[16], i_item.volume_difference};
    assign w_lim       = {2'b00, i_cfg.difference_limit};
    assign w_nlim      = -w_lim;
    assign w_temp_done = $signed(i_item.temperature) >= $signed(i_cfg.temperature_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_inlet_cmd  <= 1'b0;
            r_outlet_cmd <= 1'b0;
            r_bypass_cmd <= 1'b0;
            r_start      <= 1'b0;
            r_intr       <= 1'b0;
            r_semi_in    <= 1'b0;
            r_semi_out   <= 1'b0;
            r_report     <= 3'd0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_inlet_cmd  <= n_inlet_cmd;
            r_outlet_cmd <= n_outlet_cmd;
            r_bypass_cmd <= n_bypass_cmd;
            r_start      <= n_start;
            r_intr       <= n_intr;
            r_semi_in    <= n_semi_in;
            r_semi_out   <= n_semi_out;
            r_report     <= n_report;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_inlet_cmd  = r_inlet_cmd;
        n_outlet_cmd = r_outlet_cmd;
        n_bypass_cmd = r_bypass_cmd;
        n_report     = r_report;
        // Request pulses are latched before the mode acts on them.
        n_start      = r_start    | i_item.start_request;
        n_intr       = r_intr     | i_item.interrupt_request;
        n_semi_in    = r_semi_in  | i_item.semi_inlet_request;
        n_semi_out   = r_semi_out | i_item.semi_outlet_request;
        o_result     = '0;

        unique case (i_item.mode)
            MODE_AUTO: begin
                // Valves show the commands held from the previous tick.
                o_result.inlet_valve  = r_inlet_cmd;
                o_result.outlet_valve = r_outlet_cmd;
                unique case (r_phase)
                    PH_HEAT: begin
                        n_report     = 3'(PH_HEAT);
                        n_bypass_cmd = 1'b1;
                        if (w_temp_done || n_intr) begin
                            n_bypass_cmd = 1'b0;
                            n_phase      = PH_DRAIN;
                        end
                        if (n_intr) begin
                            n_intr = 1'b0;
                        end
                    end
                    PH_DRAIN: begin
                        n_report     = 3'(PH_DRAIN);
                        n_outlet_cmd = 1'b1;
                        if ((i_item.outlet_volume >= i_cfg.outlet_volume_target) || n_intr) begin
                            n_outlet_cmd = 1'b0;
                            n_phase      = PH_BALANCE;
                        end
                        if (n_intr) begin
                            n_intr = 1'b0;
                        end
                    end
                    PH_BALANCE: begin
                        n_report = 3'(PH_BALANCE);
                        if (w_diff > w_lim) begin
                            n_inlet_cmd  = 1'b0;
                            n_outlet_cmd = 1'b1;
                        end else if (w_diff < w_nlim) begin
                            n_inlet_cmd  = 1'b1;
                            n_outlet_cmd = 1'b0;
                        end else begin
                            n_inlet_cmd  = 1'b1;
                            n_outlet_cmd = 1'b1;
                        end
                        if (n_intr || (i_item.inlet_volume >= i_cfg.inlet_volume_target)) begin
                            n_phase = PH_FINISH;
                        end
                    end
                    PH_FINISH: begin
                        n_report     = 3'(PH_FINISH);
                        n_intr       = 1'b0;
                        n_inlet_cmd  = 1'b0;
                        n_outlet_cmd = 1'b0;
                    end
                    default: begin
                        n_report     = 3'(PH_IDLE);
                        n_inlet_cmd  = 1'b0;
                        n_outlet_cmd = 1'b0;
                        n_bypass_cmd = 1'b0;
                        n_phase      = PH_IDLE;
                        if (n_start) begin
                            n_start = 1'b0;
                            n_phase = PH_HEAT;
                        end
                    end
                endcase
            end
            MODE_MANUAL: begin
                n_phase               = PH_IDLE;
                n_start               = 1'b0;
                n_intr                = 1'b0;
                n_semi_in             = 1'b0;
                n_semi_out            = 1'b0;
                n_inlet_cmd           = i_item.manual_inlet;
                n_outlet_cmd          = i_item.manual_outlet;
                o_result.inlet_valve  = i_item.manual_inlet;
                o_result.outlet_valve = i_item.manual_outlet;
            end
            MODE_SEMI: begin
                n_phase               = PH_IDLE;
                o_result.inlet_valve  = n_semi_in &
                                        (i_item.inlet_volume <= i_cfg.inlet_volume_target);
                o_result.outlet_valve = n_semi_out &
                                        (i_item.outlet_volume <= i_cfg.outlet_volume_target);
            end
            default: begin
                n_phase    = PH_IDLE;
                n_start    = 1'b0;
                n_intr     = 1'b0;
                n_semi_in  = 1'b0;
                n_semi_out = 1'b0;
            end
        endcase

        o_result.bypass_valve = n_bypass_cmd;
        o_result.phase_number = n_report;
    end

endmodule

`default_nettype wire

// File: design/fluid_exchange_valve_sequencer_core.sv
// ----------------------------------------------------------------------------
// fluid_exchange_valve_sequencer_core - valve sequencer for a fluid exchange
// One request is one control tick carrying mode, request pulses, manual valve
// commands and sensor readings; one result with the valve drives and the
// automatic phase comes back for every request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   --------  ---------  ---------------------  -------------------------------
//   request   in         i_valid / o_stall      i_mode .. i_volume_difference
//   result    out        o_valid / i_stall      o_inlet_valve .. o_phase_number
//   config    in         psel/penable/pready    paddr, pwdata, prdata
//
// A request is registered in the input register and its result is registered
// in the output register; one request per cycle is sustained while the result
// is not stalled. The single pass through the decision logic in fevs_seq
// allows this, since the sequencer state is written as the result is.
// Reset is synchronous and active low; it clears both pipeline valids, the
// phase, commands, sticky flags and the configuration registers.
// A stalled result holds the output register; the input register still takes
// one further request, after which o_stall rises until the result moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module fluid_exchange_valve_sequencer_core import fevs_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Request channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [1:0]              i_mode,
    input  wire logic                    i_start_request,
    input  wire logic                    i_interrupt_request,
    input  wire logic                    i_semi_inlet_request,
    input  wire logic                    i_semi_outlet_request,
    input  wire logic                    i_manual_inlet,
    input  wire logic                    i_manual_outlet,
    input  wire logic signed [15:0]      i_temperature,
    input  wire logic [15:0]             i_inlet_volume,
    input  wire logic [15:0]             i_outlet_volume,
    input  wire logic signed [16:0]      i_volume_difference,
    // Result channel
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic                         o_inlet_valve,
    output logic                         o_outlet_valve,
    output logic                         o_bypass_valve,
    output logic [2:0]                   o_phase_number,
    // Configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ApbAddrWidth-1:0] paddr,
    input  wire logic [ApbDataWidth-1:0] pwdata,
    output logic      [ApbDataWidth-1:0] prdata,
    output logic                         pready
);

    t_cfg    w_cfg;
    t_item   r_item;
    t_result r_result;
    t_result w_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    w_accept;
    logic    w_advance;
    logic    w_fire;

    fevs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The output register can load whenever it is empty or being emptied.
    // The request in the input register then fires: the sequencer state and
    // the result register are written at the same edge.
    assign w_advance = ~r_out_valid | ~i_stall;
    assign w_fire    = r_in_valid & w_advance;
    assign o_stall   = r_in_valid & ~w_advance;
    assign w_accept  = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it is qualified by r_in_valid.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.mode                <= t_mode'(i_mode);
            r_item.start_request       <= i_start_request;
            r_item.interrupt_request   <= i_interrupt_request;
            r_item.semi_inlet_request  <= i_semi_inlet_request;
            r_item.semi_outlet_request <= i_semi_outlet_request;
            r_item.manual_inlet        <= i_manual_inlet;
            r_item.manual_outlet       <= i_manual_outlet;
            r_item.temperature         <= i_temperature;
            r_item.inlet_volume        <= i_inlet_volume;
            r_item.outlet_volume       <= i_outlet_volume;
            r_item.volume_difference   <= i_volume_difference;
        end
    end

    fevs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_inlet_valve  = r_result.inlet_valve;
    assign o_outlet_valve = r_result.outlet_valve;
    assign o_bypass_valve = r_result.bypass_valve;
    assign o_phase_number = r_result.phase_number;

endmodule

`default_nettype wire

// File: design/fevs_checker.sv
// ----------------------------------------------------------------------------
// fevs_checker - port-level checks for the valve sequencer
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fevs_checker import fevs_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_valid,
    input wire logic                    o_stall,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic                    o_bypass_valve,
    input wire logic [2:0]              o_phase_number,
    input wire logic                    pready
);

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result withdrawn while stalled");

    // A request held off by the core stays offered.
    a_request_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid)
        else $error("request withdrawn while stalled");

    // The bypass is only ever open while the heating phase is reported.
    a_bypass_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bypass_valve |-> o_phase_number == 3'(PH_HEAT))
        else $error("bypass open outside heating phase");

    // Reported phase stays within the defined sequence.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_phase_number <= 3'(PH_FINISH))
        else $error("phase report out of range");

    // With an empty output register the block never holds off new requests.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && pready |-> !o_stall)
        else $error("stall raised with empty output register");

endmodule

bind fluid_exchange_valve_sequencer_core fevs_checker u_fevs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_bypass_valve (o_bypass_valve),
    .o_phase_number (o_phase_number),
    .pready         (pready)
);

`default_nettype wire
